// ===== rtl/rbd_pkg.sv =====
// Shared types and constants for the rounded box distance block.
// No dependencies; used by rounded_box_distance_top.
`default_nettype none

package rbd_pkg;

  // Register and result widths (fixed point, 12 fraction bits)
  localparam int unsigned REG_WIDTH  = 23;
  localparam int unsigned OUT_WIDTH  = 27;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_WIDTH = 4;

  // Reset values: unit half extents, no rounding
  localparam logic [REG_WIDTH-1:0] HALF_SIZE_RST = 23'd4096;
  localparam logic [REG_WIDTH-1:0] RADIUS_RST    = 23'd0;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2,
    REG_RADIUS = 2'd3
  } reg_idx_e;

  // Box geometry as held by the register bank
  typedef struct packed {
    logic [REG_WIDTH-1:0] half_x;
    logic [REG_WIDTH-1:0] half_y;
    logic [REG_WIDTH-1:0] half_z;
    logic [REG_WIDTH-1:0] radius;
  } box_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rounded_box_distance_top.sv =====
// Rounded box signed distance: APB register bank, edge/square/sum stages,
// pipelined square root and saturating output. Uses rbd_pkg and rbd_isqrt.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  request  | start, busy, point_{x,y,z}_i             | taken when start & !busy
//  result   | done_o, signed_distance_o               | one-cycle strobe
//  config   | psel, penable, pwrite, paddr, pwdata,   | APB, written in access
//           | prdata, pready                          | phase, pready always 1
//
// A request is taken every cycle; busy stays low. A result passes the edge,
// square and sum stages, then the square root pipeline that resolves one root
// bit per stage, then the output register; EW = max(COORD_WIDTH,24)+2.
// Reset clears valid bits and restores the box registers; no clearing pass.
// The result side cannot stall, so the pipeline never holds.
`default_nettype none

module rounded_box_distance_top #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rbd_pkg::ADDR_WIDTH-1:0]      paddr,
  input  wire logic [rbd_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic      [rbd_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                     pready,
  // request
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]       point_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]       point_z_i,
  // result
  output logic                                     done_o,
  output logic signed [rbd_pkg::OUT_WIDTH-1:0]     signed_distance_o
);

  localparam int unsigned RWD = rbd_pkg::REG_WIDTH;
  localparam int unsigned OW  = rbd_pkg::OUT_WIDTH;
  // edge distance width: holds |p| + radius with sign
  localparam int unsigned EW  = ((COORD_WIDTH > 24) ? COORD_WIDTH : 24) + 2;
  localparam int unsigned QW  = 2 * (EW - 1);
  localparam int unsigned SW  = 2 * EW;
  localparam int unsigned DW  = EW + 2;
  localparam int unsigned LAT = EW + 4;

  // ---------------------------------------------------------------
  // Register bank
  rbd_pkg::box_cfg_t cfg_q;
  rbd_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = rbd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_x <= rbd_pkg::HALF_SIZE_RST;
      cfg_q.half_y <= rbd_pkg::HALF_SIZE_RST;
      cfg_q.half_z <= rbd_pkg::HALF_SIZE_RST;
      cfg_q.radius <= rbd_pkg::RADIUS_RST;
    end else if (wr_en) begin
      case (idx)
        rbd_pkg::REG_HALF_X: cfg_q.half_x <= pwdata[RWD-1:0];
        rbd_pkg::REG_HALF_Y: cfg_q.half_y <= pwdata[RWD-1:0];
        rbd_pkg::REG_HALF_Z: cfg_q.half_z <= pwdata[RWD-1:0];
        rbd_pkg::REG_RADIUS: cfg_q.radius <= pwdata[RWD-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      rbd_pkg::REG_HALF_X: prdata[RWD-1:0] = cfg_q.half_x;
      rbd_pkg::REG_HALF_Y: prdata[RWD-1:0] = cfg_q.half_y;
      rbd_pkg::REG_HALF_Z: prdata[RWD-1:0] = cfg_q.half_z;
      rbd_pkg::REG_RADIUS: prdata[RWD-1:0] = cfg_q.radius;
      default:             prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------
  // Stage 1: per-axis edge distance e = |p| - half + radius
  logic [COORD_WIDTH-1:0] pt   [3];
  logic [RWD-1:0]         half [3];
  logic signed [EW-1:0]   e_q  [3];
  logic                   s1_vld_q;

  assign pt[0]   = point_x_i;
  assign pt[1]   = point_y_i;
  assign pt[2]   = point_z_i;
  assign half[0] = cfg_q.half_x;
  assign half[1] = cfg_q.half_y;
  assign half[2] = cfg_q.half_z;

  for (genvar a = 0; a < 3; a++) begin : g_edge
    logic signed [EW-1:0] p_ext;
    logic signed [EW-1:0] p_abs;
    logic signed [EW-1:0] e_d;

    assign p_ext = {{(EW-COORD_WIDTH){pt[a][COORD_WIDTH-1]}}, pt[a]};
    assign p_abs = p_ext[EW-1] ? -p_ext : p_ext;
    assign e_d   = p_abs - $signed({{(EW-RWD){1'b0}}, half[a]})
                         + $signed({{(EW-RWD){1'b0}}, cfg_q.radius});

    always_ff @(posedge clk_i) begin
      e_q[a] <= e_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: squares of positive parts, inside term
  logic [QW-1:0]        sq_q [3];
  logic signed [EW-1:0] mx_xy;
  logic signed [EW-1:0] mx_all;
  logic signed [EW-1:0] in2_q;
  logic                 s2_vld_q;

  for (genvar a = 0; a < 3; a++) begin : g_sq
    logic [EW-2:0] pos;

    assign pos = (e_q[a] > 0) ? e_q[a][EW-2:0] : '0;

    always_ff @(posedge clk_i) begin
      sq_q[a] <= pos * pos;
    end
  end

  assign mx_xy  = (e_q[1] > e_q[0]) ? e_q[1] : e_q[0];
  assign mx_all = (e_q[2] > mx_xy) ? e_q[2] : mx_xy;

  always_ff @(posedge clk_i) begin
    in2_q <= mx_all[EW-1] ? mx_all : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: sum of squares
  logic [SW-1:0]        sum_q;
  logic signed [EW-1:0] in3_q;
  logic                 s3_vld_q;

  always_ff @(posedge clk_i) begin
    sum_q <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    in3_q <= in2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  // ---------------------------------------------------------------
  // Square root pipeline, inside term rides along as the tag
  logic          sq_vld;
  logic [EW-1:0] sq_root;
  logic [EW-1:0] sq_tag;

  rbd_isqrt #(
    .RW    (EW),
    .TAG_W (EW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s3_vld_q),
    .rad_i  (sum_q),
    .tag_i  (in3_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .tag_o  (sq_tag)
  );

  // ---------------------------------------------------------------
  // Output: outside + inside - radius, saturated
  logic signed [DW-1:0] dsum;
  logic signed [DW-1:0] sat_hi;
  logic signed [DW-1:0] sat_lo;
  logic signed [OW-1:0] dist_d;
  logic signed [OW-1:0] dist_q;
  logic                 done_q;

  assign sat_hi = {{(DW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  assign sat_lo = {{(DW-OW+1){1'b1}}, {(OW-1){1'b0}}};
  assign dsum   = $signed({2'b00, sq_root})
                + $signed({{2{sq_tag[EW-1]}}, sq_tag})
                - $signed({{(DW-RWD){1'b0}}, cfg_q.radius});

  always_comb begin
    if (dsum > sat_hi) begin
      dist_d = sat_hi[OW-1:0];
    end else if (dsum < sat_lo) begin
      dist_d = sat_lo[OW-1:0];
    end else begin
      dist_d = dsum[OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sq_vld;
    end
  end

  assign done_o            = done_q;
  assign signed_distance_o = dist_q;

  // ---------------------------------------------------------------
  // Every request yields a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result strobe missing after request");

  // Inside term is never positive
  a_inside_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (in2_q[EW-1] || (in2_q == '0)))
    else $error("inside term positive");

  // A nonzero x square only comes from a positive x edge distance
  a_sq_from_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && (sq_q[0] != '0)) |-> $past(e_q[0] > 0))
    else $error("square of nonpositive edge distance");

endmodule

`default_nettype wire

// ===== rtl/rbd_isqrt.sv =====
// Pipelined integer square root (floor), one root bit per stage.
// Carries a sideband tag alongside each request. No package dependency.
`default_nettype none

module rbd_isqrt #(
  parameter int unsigned RW    = 26,
  parameter int unsigned TAG_W = 26
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire logic [2*RW-1:0]   rad_i,
  input  wire logic [TAG_W-1:0]  tag_i,
  output logic                   vld_o,
  output logic [RW-1:0]          root_o,
  output logic [TAG_W-1:0]       tag_o
);

  // Stage 0 is the input; stages 1..RW are registers
  logic              vld  [RW+1];
  logic [2*RW-1:0]   rad  [RW+1];
  logic [RW:0]       rem  [RW+1];
  logic [RW-1:0]     root [RW+1];
  logic [TAG_W-1:0]  tag  [RW+1];

  assign vld[0]  = vld_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = tag_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0] acc;
    logic [RW+2:0] trial;
    logic          ge;
    logic [RW+2:0] diff;

    // Bring down the next two radicand bits and try root*4+1
    assign acc   = {rem[k], rad[k][2*RW-1 -: 2]};
    assign trial = {1'b0, root[k], 2'b01};
    assign ge    = (acc >= trial);
    assign diff  = acc - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rad[k+1]  <= {rad[k][2*RW-3:0], 2'b00};
      rem[k+1]  <= ge ? diff[RW:0] : acc[RW:0];
      root[k+1] <= {root[k][RW-2:0], ge};
      tag[k+1]  <= tag[k];
    end
  end

  assign vld_o  = vld[RW];
  assign root_o = root[RW];
  assign tag_o  = tag[RW];

  // Final remainder of an exact floor root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[RW] |-> ({1'b0, rem[RW]} <= {1'b0, root[RW], 1'b0}))
    else $error("isqrt remainder above bound");

endmodule

`default_nettype wire
